@@ design/precharge_sequencer_defines.svh @@
// ----------------------------------------------------------------------------
// precharge sequencer assertion macros
// shared property forms for the checker of the precharge sequencer
// ----------------------------------------------------------------------------
`ifndef PRECHARGE_SEQUENCER_DEFINES_SVH
`define PRECHARGE_SEQUENCER_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define PC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define PC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/pc_pkg.sv @@
// ----------------------------------------------------------------------------
// pc_pkg
// types, codes and constants shared by the precharge sequencer files
// ----------------------------------------------------------------------------
package pc_pkg;

	// stream and register port geometry
	localparam int IN_TDATA_W  = 88;
	localparam int OUT_TDATA_W = 56;
	localparam int PADDR_W     = 5;
	localparam int PDATA_W     = 32;

	// datapath widths
	localparam int LEVEL_W = 32;
	localparam int PROD_W  = 48;
	localparam int CMP_W   = 42;
	localparam int DIV_DVD_W = 39;
	localparam int DIV_DVS_W = 32;

	// scale factors of the progress and readiness products
	localparam logic [15:0] PCT_SCALE      = 16'd100;
	localparam logic [15:0] PERMILLE_SCALE = 16'd1000;
	localparam logic [15:0] PROGRESS_MAX   = 16'hFFFF;

	// register reset values
	localparam logic [15:0] RST_MIN_ACC_V  = 16'd0;
	localparam logic [9:0]  RST_TARGET     = 10'd900;
	localparam logic [15:0] RST_MIN_PRE    = 16'd3000;
	localparam logic [15:0] RST_MAX_PRE    = 16'd10000;
	localparam logic [7:0]  RST_STABLE     = 8'd20;
	localparam logic [15:0] RST_BMS_TMO    = 16'd1000;
	localparam logic [15:0] RST_ALPHA      = 16'd16384;
	localparam logic [15:0] RST_DIS_DONE   = 16'd500;

	// operating modes; none marks a previous mode that was never set
	typedef enum logic [2:0] {
		MODE_STANDBY   = 3'd0,
		MODE_PRECHARGE = 3'd1,
		MODE_DISCHARGE = 3'd2,
		MODE_ONLINE    = 3'd3,
		MODE_CHARGING  = 3'd4,
		MODE_ERROR     = 3'd5,
		MODE_NONE      = 3'd7
	} pc_mode_t;

	// register indexes
	typedef enum logic [2:0] {
		REG_MIN_ACC_V = 3'd0,
		REG_TARGET    = 3'd1,
		REG_MIN_PRE   = 3'd2,
		REG_MAX_PRE   = 3'd3,
		REG_STABLE    = 3'd4,
		REG_BMS_TMO   = 3'd5,
		REG_ALPHA     = 3'd6,
		REG_DIS_DONE  = 3'd7
	} pc_reg_t;

	// per-tick sequencer steps
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ACC_MUL,
		ST_BUS_MUL,
		ST_BUS_APPLY,
		ST_MUL100,
		ST_MUL1000,
		ST_MUL_TGT,
		ST_COMPARE,
		ST_DIVIDE,
		ST_UPDATE
	} pc_seq_t;

	// error flag positions
	localparam int ERR_TOO_SLOW = 0;
	localparam int ERR_BMS_TMO  = 1;

	// divider status towards the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} pc_div_status_t;

endpackage

@@ design/pc_divider.sv @@
// ----------------------------------------------------------------------------
// pc_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pc_divider
	import pc_pkg::*;
#(
	parameter int DVD_W = DIV_DVD_W,
	parameter int DVS_W = DIV_DVS_W
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DVD_W-1:0]     dividend,
	input  logic [DVS_W-1:0]     divisor,
	output logic [DVD_W-1:0]     quotient,
	output pc_div_status_t       status
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W:0]   shifted;
	logic [DVS_W:0]   trial;
	logic             fits;

	// trial subtraction of the divisor from the shifted remainder
	assign shifted = {rem_q, quo_q[DVD_W-1]};
	assign trial   = shifted - {1'b0, dvs_q};
	assign fits    = !trial[DVS_W];

	// step counter and completion flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(DVD_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				done_q <= 1'b1;
			end
		end
	end

	// remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign quotient    = quo_q;
	assign status.busy = (cnt_q != '0);
	assign status.done = done_q;

endmodule

@@ design/precharge_sequencer.sv @@
// ----------------------------------------------------------------------------
// precharge_sequencer
// precharge, discharge and charging sequencer with filtered voltages
// ----------------------------------------------------------------------------
// One tick per input transfer: both voltage filters, the progress ratio and
// the readiness test go through a single shared 32x16 multiplier in five
// steps, then a restoring divider forms 100*bus/acc one bit per cycle.
// s_tready is high only between ticks. The result sits in an output
// register, so the next tick is taken while it waits, and a tick only
// stalls at its final step if the previous result is still held.
// Registers are written over APB at byte address 4*index.
module precharge_sequencer
	import pc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// now_ms[31:0], acc_raw[47:32], bus_raw[63:48], charger_safety[64],
	// bms_age_ms[80:65], zero fill above
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// mode[2:0], error_flags[4:3], acc_filtered[20:5], bus_filtered[36:21],
	// progress_pct[52:37], shutdown_drive[53], zero fill above
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [PADDR_W-1:0]     paddr,
	input  logic [PDATA_W-1:0]     pwdata,
	output logic [PDATA_W-1:0]     prdata,
	output logic                   pready
);

	// configuration registers
	logic [15:0] min_acc_q, min_pre_q, max_pre_q, bms_tmo_q, alpha_q, dis_done_q;
	logic [9:0]  target_q;
	logic [7:0]  stable_q;
	logic        cfg_wr;

	// captured tick
	logic [31:0] now_q;
	logic [15:0] acc_raw_q, bus_raw_q, bms_age_q;
	logic        charger_q;

	// controller state
	pc_seq_t     state_q, state_d;
	pc_mode_t    mode_q, mode_d, prev_q, prev_d;
	logic [LEVEL_W-1:0] acc_level_q, bus_level_q;
	logic [31:0] start_q, start_d, below_q, below_d;
	logic [15:0] prog_q, prog_d;
	logic [1:0]  err_q, err_d;
	logic        shut_q, shut_d;

	// shared multiplier and its operands
	logic [LEVEL_W-1:0] mul_a;
	logic [15:0]        mul_b;
	logic               mul_en;
	logic [PROD_W-1:0]  mul_prod, prod_q;

	// filter working values
	logic [LEVEL_W:0]   acc_diff, bus_diff;
	logic [LEVEL_W-1:0] acc_mag, bus_mag;
	logic               acc_up_q, acc_load_q, bus_up_q;

	// precharge evaluation values
	logic [CMP_W-1:0]     lhs_q;
	logic                 ready_q;
	logic [31:0]          el_start_q, el_below_q;
	logic                 div_start;
	logic [DIV_DVD_W-1:0] quotient;
	pc_div_status_t       div_status;

	// output register
	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;
	logic                   out_free;

	// mode decision inputs
	logic        acc_low, bus_done, acc_zero, ready, stable, min_done, too_slow;
	logic [15:0] progress_calc;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_acc_q  <= RST_MIN_ACC_V;
			target_q   <= RST_TARGET;
			min_pre_q  <= RST_MIN_PRE;
			max_pre_q  <= RST_MAX_PRE;
			stable_q   <= RST_STABLE;
			bms_tmo_q  <= RST_BMS_TMO;
			alpha_q    <= RST_ALPHA;
			dis_done_q <= RST_DIS_DONE;
		end else if (cfg_wr) begin
			unique case (pc_reg_t'(paddr[4:2]))
				REG_MIN_ACC_V: min_acc_q  <= pwdata[15:0];
				REG_TARGET:    target_q   <= pwdata[9:0];
				REG_MIN_PRE:   min_pre_q  <= pwdata[15:0];
				REG_MAX_PRE:   max_pre_q  <= pwdata[15:0];
				REG_STABLE:    stable_q   <= pwdata[7:0];
				REG_BMS_TMO:   bms_tmo_q  <= pwdata[15:0];
				REG_ALPHA:     alpha_q    <= pwdata[15:0];
				REG_DIS_DONE:  dis_done_q <= pwdata[15:0];
			endcase
		end
	end

	// register reads
	always_comb begin
		unique case (pc_reg_t'(paddr[4:2]))
			REG_MIN_ACC_V: prdata = {16'b0, min_acc_q};
			REG_TARGET:    prdata = {22'b0, target_q};
			REG_MIN_PRE:   prdata = {16'b0, min_pre_q};
			REG_MAX_PRE:   prdata = {16'b0, max_pre_q};
			REG_STABLE:    prdata = {24'b0, stable_q};
			REG_BMS_TMO:   prdata = {16'b0, bms_tmo_q};
			REG_ALPHA:     prdata = {16'b0, alpha_q};
			REG_DIS_DONE:  prdata = {16'b0, dis_done_q};
		endcase
	end

	// capture of the accepted transfer
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			now_q     <= s_tdata[31:0];
			acc_raw_q <= s_tdata[47:32];
			bus_raw_q <= s_tdata[63:48];
			charger_q <= s_tdata[64];
			bms_age_q <= s_tdata[80:65];
		end
	end

	// distance of each level from its sample, as magnitude and direction
	assign acc_diff = {1'b0, acc_raw_q, 16'b0} - {1'b0, acc_level_q};
	assign bus_diff = {1'b0, bus_raw_q, 16'b0} - {1'b0, bus_level_q};
	assign acc_mag  = acc_diff[LEVEL_W] ? (~acc_diff[LEVEL_W-1:0] + 1'b1)
	                                    : acc_diff[LEVEL_W-1:0];
	assign bus_mag  = bus_diff[LEVEL_W] ? (~bus_diff[LEVEL_W-1:0] + 1'b1)
	                                    : bus_diff[LEVEL_W-1:0];

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (s_tvalid) state_d = ST_ACC_MUL;
			ST_ACC_MUL:   state_d = ST_BUS_MUL;
			ST_BUS_MUL:   state_d = ST_BUS_APPLY;
			ST_BUS_APPLY: state_d = ST_MUL100;
			ST_MUL100:    state_d = ST_MUL1000;
			ST_MUL1000:   state_d = ST_MUL_TGT;
			ST_MUL_TGT:   state_d = ST_COMPARE;
			ST_COMPARE:   state_d = ST_DIVIDE;
			ST_DIVIDE:    if (div_status.done && !div_status.busy) state_d = ST_UPDATE;
			ST_UPDATE:    if (out_free) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs: multiplier operands and divider start
	always_comb begin
		mul_a     = '0;
		mul_b     = '0;
		mul_en    = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			ST_ACC_MUL: begin
				mul_a  = acc_mag;
				mul_b  = alpha_q;
				mul_en = 1'b1;
			end
			ST_BUS_MUL: begin
				mul_a  = bus_mag;
				mul_b  = alpha_q;
				mul_en = 1'b1;
			end
			ST_MUL100: begin
				mul_a  = bus_level_q;
				mul_b  = PCT_SCALE;
				mul_en = 1'b1;
			end
			ST_MUL1000: begin
				mul_a     = bus_level_q;
				mul_b     = PERMILLE_SCALE;
				mul_en    = 1'b1;
				div_start = 1'b1;
			end
			ST_MUL_TGT: begin
				mul_a  = acc_level_q;
				mul_b  = {6'b0, target_q};
				mul_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// shared multiplier with registered product
	assign mul_prod = PROD_W'(mul_a) * PROD_W'(mul_b);

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= mul_prod;
		end
	end

	// progress division
	pc_divider #(
		.DVD_W (DIV_DVD_W),
		.DVS_W (DIV_DVS_W)
	) u_pc_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q[DIV_DVD_W-1:0]),
		.divisor  (acc_level_q),
		.quotient (quotient),
		.status   (div_status)
	);

	// per-step working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_ACC_MUL: begin
				acc_up_q   <= !acc_diff[LEVEL_W];
				acc_load_q <= (acc_level_q == '0) && (acc_raw_q != '0);
			end
			ST_BUS_MUL: bus_up_q <= !bus_diff[LEVEL_W];
			ST_MUL1000: el_start_q <= (prev_q != MODE_PRECHARGE) ? '0 : now_q - start_q;
			ST_MUL_TGT: begin
				lhs_q      <= prod_q[CMP_W-1:0];
				el_below_q <= now_q - below_q;
			end
			ST_COMPARE: ready_q <= (lhs_q >= prod_q[CMP_W-1:0]);
			default: begin
			end
		endcase
	end

	// filter levels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_level_q <= '0;
			bus_level_q <= '0;
		end else if (state_q == ST_BUS_MUL) begin
			if (acc_load_q) begin
				acc_level_q <= {acc_raw_q, 16'b0};
			end else if (acc_up_q) begin
				acc_level_q <= acc_level_q + prod_q[PROD_W-1:16];
			end else begin
				acc_level_q <= acc_level_q - prod_q[PROD_W-1:16];
			end
		end else if (state_q == ST_BUS_APPLY) begin
			if (bus_up_q) begin
				bus_level_q <= bus_level_q + prod_q[PROD_W-1:16];
			end else begin
				bus_level_q <= bus_level_q - prod_q[PROD_W-1:16];
			end
		end
	end

	// decision terms on the new levels
	assign acc_low  = (acc_level_q[31:16] < min_acc_q);
	assign bus_done = (bus_level_q[31:16] < dis_done_q) ||
	                  ((bus_level_q[31:16] == dis_done_q) && (bus_level_q[15:0] == '0));
	assign acc_zero = (acc_level_q == '0);
	assign ready    = acc_zero || ready_q;
	assign stable   = (el_below_q >= {24'b0, stable_q});
	assign min_done = (el_start_q >= {16'b0, min_pre_q});
	assign too_slow = (el_start_q > {16'b0, max_pre_q});
	assign progress_calc = (acc_zero || (quotient[DIV_DVD_W-1:16] != '0)) ? PROGRESS_MAX
	                                                                      : quotient[15:0];

	// mode machine; later assignments within a tick override earlier ones
	always_comb begin
		mode_d  = mode_q;
		prev_d  = prev_q;
		start_d = start_q;
		below_d = below_q;
		prog_d  = prog_q;
		err_d   = err_q;
		shut_d  = shut_q;
		unique case (mode_q)
			MODE_STANDBY: begin
				shut_d = 1'b0;
				if (!acc_low) begin
					prev_d = MODE_STANDBY;
					mode_d = MODE_PRECHARGE;
				end
			end
			MODE_PRECHARGE: begin
				if (acc_low) mode_d = MODE_DISCHARGE;
				if (prev_q != MODE_PRECHARGE) begin
					prev_d  = MODE_PRECHARGE;
					start_d = now_q;
				end
				prog_d = progress_calc;
				if (ready && stable && min_done) begin
					mode_d = charger_q ? MODE_CHARGING : MODE_ONLINE;
				end else begin
					if (!ready) below_d = now_q;
					if (too_slow) begin
						mode_d              = MODE_ERROR;
						err_d[ERR_TOO_SLOW] = 1'b1;
					end
				end
			end
			MODE_DISCHARGE: begin
				if (bus_done) mode_d = MODE_STANDBY;
			end
			MODE_ONLINE: begin
				if (acc_low) mode_d = MODE_DISCHARGE;
				if (charger_q) begin
					mode_d = MODE_CHARGING;
				end else begin
					prev_d = MODE_ONLINE;
					shut_d = 1'b1;
				end
			end
			MODE_CHARGING: begin
				priority if (acc_low) begin
					mode_d = MODE_DISCHARGE;
				end else if (!charger_q) begin
					mode_d = MODE_STANDBY;
				end else if (bms_age_q > bms_tmo_q) begin
					mode_d             = MODE_ERROR;
					err_d[ERR_BMS_TMO] = 1'b1;
				end else begin
					prev_d = MODE_CHARGING;
				end
			end
			MODE_ERROR: begin
				if (acc_low) mode_d = MODE_DISCHARGE;
				shut_d = 1'b0;
				prev_d = MODE_ERROR;
			end
			default: begin
				mode_d = MODE_ERROR;
				shut_d = 1'b0;
				prev_d = MODE_ERROR;
			end
		endcase
	end

	// controller state, committed at the final step of a tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q  <= MODE_STANDBY;
			prev_q  <= MODE_NONE;
			start_q <= '0;
			below_q <= '0;
			prog_q  <= '0;
			err_q   <= '0;
			shut_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_UPDATE && out_free) begin
				mode_q  <= mode_d;
				prev_q  <= prev_d;
				start_q <= start_d;
				below_q <= below_d;
				prog_q  <= prog_d;
				err_q   <= err_d;
				shut_q  <= shut_d;
			end
		end
	end

	// result register towards the master side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_UPDATE && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_UPDATE && out_free) begin
			m_tdata_q <= {2'b0, shut_d, prog_d, bus_level_q[31:16], acc_level_q[31:16],
			              err_d, 3'(mode_d)};
		end
	end

endmodule

@@ design/pc_checker.sv @@
// ----------------------------------------------------------------------------
// pc_checker
// port-level checks of the precharge sequencer, bound to the top level
// ----------------------------------------------------------------------------
`include "precharge_sequencer_defines.svh"

module pc_checker
	import pc_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	// a stalled result holds its value
	`PC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

	// a tick keeps the block busy after its transfer
	`PC_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready stayed high after accept")

	// error mode is only reached through a recorded fault
	`PC_ASSERT_NOW(a_error_flagged, m_tvalid && (m_tdata[2:0] == 3'(MODE_ERROR)), m_tdata[4:3] != 2'b00, "error mode without error flag")

endmodule

bind precharge_sequencer pc_checker u_pc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// precharge sequencer testbench
// ----------------------------------------------------------------------------
// Sends ticks over the input stream in random bursts while the result stream
// stalls on its own pattern. A behavioural copy of the sequencer predicts
// every result, and results are checked in order as they arrive. Registers
// are rewritten between phases once the block has drained. The phases run
// from reset values through all-zero and all-ones settings to random ones.
// ----------------------------------------------------------------------------
module testbench;
	import pc_pkg::*;

	// input tick, packed as on s_tdata, fields listed from the top bit down
	typedef struct packed {
		logic [15:0] bms_age;
		logic        charger;
		logic [15:0] bus_raw;
		logic [15:0] acc_raw;
		logic [31:0] now;
	} tick_t;

	// result, packed as on m_tdata, fields listed from the top bit down
	typedef struct packed {
		logic        shutdown;
		logic [15:0] progress;
		logic [15:0] bus_f;
		logic [15:0] acc_f;
		logic [1:0]  flags;
		logic [2:0]  mode;
	} tick_result_t;

	localparam int TICK_W = $bits(tick_t);
	localparam int RES_W  = $bits(tick_result_t);

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   psel = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite = 1'b0;
	logic [PADDR_W-1:0]     paddr = '0;
	logic [PDATA_W-1:0]     pwdata = '0;
	logic [PDATA_W-1:0]     prdata;
	logic                   pready;

	precharge_sequencer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// predictor copy of the register file
	logic [15:0] floor_v      = RST_MIN_ACC_V;
	logic [9:0]  target_pm    = RST_TARGET;
	logic [15:0] min_pre_ms   = RST_MIN_PRE;
	logic [15:0] max_pre_ms   = RST_MAX_PRE;
	logic [7:0]  settle_ms    = RST_STABLE;
	logic [15:0] bms_limit_ms = RST_BMS_TMO;
	logic [15:0] alpha        = RST_ALPHA;
	logic [15:0] done_v       = RST_DIS_DONE;

	// predictor copy of the sequencer state
	pc_mode_t    mode_q      = MODE_STANDBY;
	pc_mode_t    last_mode   = MODE_NONE;
	logic [31:0] acc_lvl     = '0;
	logic [31:0] bus_lvl     = '0;
	logic [31:0] pre_start   = '0;
	logic [31:0] below_since = '0;
	logic [15:0] progress    = '0;
	logic [1:0]  fault_flags = '0;
	logic        shutdown    = 1'b0;

	tick_t        pending_ticks[$];
	tick_result_t expected_results[$];
	int           queued_ticks = 0;
	int           accepted_ticks = 0;
	int           mismatches = 0;
	int           burst_left = 0;
	int           gap_left = 0;
	int           rx_run_left = 0;
	bit           rx_go;
	tick_result_t got_res;
	tick_result_t want_res;
	logic [31:0]  clock_ms = '0;

	// first-order low-pass step on a Q16.16 level
	function automatic logic [31:0] lowpass(logic [31:0] level, logic [15:0] raw);
		logic [63:0] goal;
		logic [63:0] lvl;
		logic [63:0] step;
		goal = {32'd0, raw, 16'd0};
		lvl = {32'd0, level};
		if (goal >= lvl) begin
			step = ((goal - lvl) * {48'd0, alpha}) >> 16;
			return level + step[31:0];
		end
		step = ((lvl - goal) * {48'd0, alpha}) >> 16;
		return level - step[31:0];
	endfunction

	// advance the sequencer by one tick and return the result it drives
	function automatic tick_result_t predict_tick(tick_t t);
		logic        low;
		logic        ready;
		logic [63:0] q;
		logic [31:0] since_start;
		logic [31:0] since_below;
		tick_result_t r;
		if (acc_lvl == 32'd0 && t.acc_raw != 16'd0)
			acc_lvl = {t.acc_raw, 16'd0};
		else
			acc_lvl = lowpass(acc_lvl, t.acc_raw);
		bus_lvl = lowpass(bus_lvl, t.bus_raw);
		low = acc_lvl < {floor_v, 16'd0};

		case (mode_q)
		MODE_STANDBY: begin
			shutdown = 1'b0;
			if (!low) begin
				last_mode = MODE_STANDBY;
				mode_q = MODE_PRECHARGE;
			end
		end
		MODE_PRECHARGE: begin
			// dropping below the floor is overridden by completion or timeout
			if (low)
				mode_q = MODE_DISCHARGE;
			if (last_mode != MODE_PRECHARGE) begin
				last_mode = MODE_PRECHARGE;
				pre_start = t.now;
			end
			if (acc_lvl == 32'd0) begin
				progress = PROGRESS_MAX;
				ready = 1'b1;
			end else begin
				q = ({32'd0, bus_lvl} * {48'd0, PCT_SCALE}) / {32'd0, acc_lvl};
				progress = (q > {48'd0, PROGRESS_MAX}) ? PROGRESS_MAX : q[15:0];
				ready = {32'd0, bus_lvl} * {48'd0, PERMILLE_SCALE} >=
					{54'd0, target_pm} * {32'd0, acc_lvl};
			end
			since_below = t.now - below_since;
			since_start = t.now - pre_start;
			if (ready && since_below >= {24'd0, settle_ms} &&
				since_start >= {16'd0, min_pre_ms}) begin
				mode_q = t.charger ? MODE_CHARGING : MODE_ONLINE;
			end else begin
				if (!ready)
					below_since = t.now;
				if (since_start > {16'd0, max_pre_ms}) begin
					mode_q = MODE_ERROR;
					fault_flags[ERR_TOO_SLOW] = 1'b1;
				end
			end
		end
		MODE_DISCHARGE: begin
			if (bus_lvl <= {done_v, 16'd0})
				mode_q = MODE_STANDBY;
		end
		MODE_ONLINE: begin
			// charger wins over discharge; otherwise shutdown stays driven
			if (low)
				mode_q = MODE_DISCHARGE;
			if (t.charger) begin
				mode_q = MODE_CHARGING;
			end else begin
				last_mode = MODE_ONLINE;
				shutdown = 1'b1;
			end
		end
		MODE_CHARGING: begin
			if (low) begin
				mode_q = MODE_DISCHARGE;
			end else if (!t.charger) begin
				mode_q = MODE_STANDBY;
			end else if (t.bms_age > bms_limit_ms) begin
				mode_q = MODE_ERROR;
				fault_flags[ERR_BMS_TMO] = 1'b1;
			end else begin
				last_mode = MODE_CHARGING;
			end
		end
		MODE_ERROR: begin
			if (low)
				mode_q = MODE_DISCHARGE;
			shutdown = 1'b0;
			last_mode = MODE_ERROR;
		end
		default: begin
			mode_q = MODE_ERROR;
			shutdown = 1'b0;
			last_mode = MODE_ERROR;
		end
		endcase

		r.mode = mode_q;
		r.flags = fault_flags;
		r.acc_f = acc_lvl[31:16];
		r.bus_f = bus_lvl[31:16];
		r.progress = progress;
		r.shutdown = shutdown;
		return r;
	endfunction

	// tick driver: bursts of random length separated by random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_results.push_back(predict_tick(s_tdata[TICK_W-1:0]));
				accepted_ticks++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					s_tvalid <= 1'b0;
				end else if (pending_ticks.size() != 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= {{(IN_TDATA_W-TICK_W){1'b0}}, pending_ticks.pop_front()};
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 24);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor with its own ready pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_res = m_tdata[RES_W-1:0];
				if (expected_results.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result: mode %0d flags %0d acc %0d bus %0d",
							got_res.mode, got_res.flags, got_res.acc_f, got_res.bus_f,
							" progress %0d shutdown %0d", got_res.progress,
							got_res.shutdown);
					mismatches++;
				end else begin
					want_res = expected_results.pop_front();
					if (got_res !== want_res) begin
						if (mismatches < 10)
							$display("result mismatch at %0t:", $realtime,
								" mode %0d/%0d flags %0d/%0d acc %0d/%0d bus %0d/%0d",
								want_res.mode, got_res.mode, want_res.flags,
								got_res.flags, want_res.acc_f, got_res.acc_f,
								want_res.bus_f, got_res.bus_f,
								" progress %0d/%0d shutdown %0d/%0d (expected/actual)",
								want_res.progress, got_res.progress,
								want_res.shutdown, got_res.shutdown);
						mismatches++;
					end
				end
			end
			if (rx_run_left != 0) begin
				rx_run_left <= rx_run_left - 1;
			end else begin
				rx_go = ($urandom_range(0, 2) != 0);
				m_tready <= rx_go;
				rx_run_left <= rx_go ? $urandom_range(1, 300) : $urandom_range(1, 120);
			end
		end
	end

	task automatic push_tick(logic [31:0] now, int acc, int bus, bit ch, int bms);
		tick_t t;
		t.now = now;
		t.acc_raw = acc[15:0];
		t.bus_raw = bus[15:0];
		t.charger = ch;
		t.bms_age = bms[15:0];
		pending_ticks.push_back(t);
		queued_ticks++;
	endtask

	// one tick of a sequence: time moves on, bms age mostly within limit
	task automatic push_step(int dt_max, int acc, int bus, bit ch);
		int bms;
		int acc_j;
		if ($urandom_range(0, 15) == 0)
			clock_ms = clock_ms + $urandom_range(1, 4 * dt_max);
		else
			clock_ms = clock_ms + $urandom_range(1, dt_max);
		if ($urandom_range(0, 9) == 0)
			bms = $urandom_range(bms_limit_ms, 65535);
		else
			bms = $urandom_range(0, bms_limit_ms);
		acc_j = acc + $urandom_range(0, 64) - 32;
		if (acc_j < 0)
			acc_j = 0;
		if (acc_j > 65535)
			acc_j = 65535;
		if (bus > 65535)
			bus = 65535;
		push_tick(clock_ms, acc_j, bus, ch, bms);
	endtask

	// precharge ramp, a hold near target, then discharge, charger off or neither
	task automatic queue_cycle(int dt_max);
		int lo;
		int acc_nom;
		int n;
		int i;
		bit ch;
		lo = floor_v + 200;
		if (lo > 65535)
			lo = 65535;
		acc_nom = $urandom_range(65535, lo);
		ch = $urandom_range(0, 1);
		n = $urandom_range(1, 10);
		for (i = 1; i <= n; i++)
			push_step(dt_max, acc_nom, acc_nom * i / n, ch);
		n = $urandom_range(1, 14);
		for (i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0)
				ch = !ch;
			push_step(dt_max, acc_nom, acc_nom * $urandom_range(85, 106) / 100, ch);
		end
		case ($urandom_range(0, 2))
		0: begin
			n = $urandom_range(1, 4);
			for (i = 0; i < n; i++)
				push_step(dt_max, $urandom_range(0, floor_v), $urandom_range(0, done_v), ch);
		end
		1: begin
			push_step(dt_max, acc_nom, acc_nom, 1'b0);
			push_step(dt_max, acc_nom, acc_nom, 1'b0);
		end
		default: ;
		endcase
	endtask

	// register write with random bits above the field width
	task automatic write_reg(pc_reg_t idx, int value);
		logic [31:0] word;
		word = $urandom();
		case (idx)
		REG_MIN_ACC_V: begin word[15:0] = value[15:0]; floor_v = word[15:0]; end
		REG_TARGET:    begin word[9:0] = value[9:0]; target_pm = word[9:0]; end
		REG_MIN_PRE:   begin word[15:0] = value[15:0]; min_pre_ms = word[15:0]; end
		REG_MAX_PRE:   begin word[15:0] = value[15:0]; max_pre_ms = word[15:0]; end
		REG_STABLE:    begin word[7:0] = value[7:0]; settle_ms = word[7:0]; end
		REG_BMS_TMO:   begin word[15:0] = value[15:0]; bms_limit_ms = word[15:0]; end
		REG_ALPHA:     begin word[15:0] = value[15:0]; alpha = word[15:0]; end
		REG_DIS_DONE:  begin word[15:0] = value[15:0]; done_v = word[15:0]; end
		endcase
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// wait until every tick is taken and every result is back
	task automatic settle();
		while (accepted_ticks != queued_ticks || expected_results.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// stimulus
	initial begin
		int phase;
		int r;
		int goal;
		int dt_max;
		int cfg[8];
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: zero accumulator in precharge, online, charging, bms timeout
		push_tick(32'd0, 0, 0, 1'b0, 0);
		push_tick(32'd100, 0, 0, 1'b0, 0);
		push_tick(32'd3200, 0, 0, 1'b0, 0);
		push_tick(32'd3210, 40000, 0, 1'b1, 0);
		push_tick(32'd3220, 40000, 0, 1'b1, 65535);
		push_tick(32'hFFFF_FFFF, 65535, 65535, 1'b1, 0);

		for (phase = 1; phase <= 9; phase++) begin
			settle();
			case (phase)
			1: cfg = '{30000, 1023, 50, 200, 10, 1000, 65535, 500};
			2: cfg = '{0, 0, 0, 0, 0, 0, 0, 0};
			3: cfg = '{65535, 1023, 65535, 65535, 255, 65535, 65535, 65535};
			default: begin
				cfg[0] = $urandom_range(500, 30000);
				cfg[1] = $urandom_range(500, 1023);
				cfg[2] = $urandom_range(0, 300);
				cfg[3] = cfg[2] + $urandom_range(0, 800);
				cfg[4] = $urandom_range(0, 255);
				cfg[5] = $urandom_range(50, 2000);
				cfg[6] = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 65535)
					: $urandom_range(4000, 65535);
				cfg[7] = $urandom_range(0, 5000);
			end
			endcase
			for (r = 0; r < 8; r++)
				write_reg(pc_reg_t'(r), cfg[r]);

			if (phase == 1) begin
				// error to discharge, target above full scale, floor drop while
				// online, too-slow timeout, charging exit, floor drop in precharge
				push_tick(32'd5000, 0, 0, 1'b0, 0);
				push_tick(32'd5010, 0, 0, 1'b0, 0);
				push_tick(32'd5020, 35000, 0, 1'b0, 0);
				push_tick(32'd5030, 35000, 20000, 1'b0, 0);
				push_tick(32'd5100, 35000, 36000, 1'b0, 0);
				push_tick(32'd5110, 20000, 36000, 1'b0, 0);
				push_tick(32'd5120, 35000, 0, 1'b0, 0);
				push_tick(32'd5130, 35000, 0, 1'b0, 0);
				push_tick(32'd5140, 35000, 0, 1'b0, 0);
				push_tick(32'd5400, 35000, 0, 1'b0, 0);
				push_tick(32'd5410, 20000, 0, 1'b0, 0);
				push_tick(32'd5420, 35000, 0, 1'b0, 0);
				push_tick(32'd5430, 35000, 0, 1'b1, 0);
				push_tick(32'd5440, 35000, 36000, 1'b1, 0);
				push_tick(32'd5500, 35000, 36000, 1'b1, 0);
				push_tick(32'd5510, 35000, 36000, 1'b1, 100);
				push_tick(32'd5520, 35000, 36000, 1'b0, 100);
				push_tick(32'd5530, 35000, 36000, 1'b0, 0);
				push_tick(32'd5540, 20000, 36000, 1'b0, 0);
			end

			// random sequences, one phase starting just short of time wrap
			clock_ms = (phase == 5) ? 32'hFFFF_FF00 : $urandom();
			dt_max = max_pre_ms / 6 + 2;
			goal = queued_ticks + ((phase <= 3) ? 95 : 110);
			while (queued_ticks < goal) begin
				if ($urandom_range(0, 7) == 0)
					push_tick($urandom(), $urandom_range(0, 65535), $urandom_range(0, 65535),
						$urandom_range(0, 1), $urandom_range(0, 65535));
				else
					queue_cycle(dt_max);
			end
		end

		settle();
		if (mismatches == 0 && expected_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#4000000;
		$display("FAIL");
		$finish;
	end

endmodule
